// File: rtl/aop_pkg.sv
// Package with shared constants, mode codes and control types for the AABB overlap unit.
`timescale 1ns / 1ps

package aop_pkg;

  // Default coordinate width of every edge and movement field.
  localparam int unsigned COORD_BITS = 16;

  // Mode codes carried on the input tuser.
  localparam logic [1:0] MODE_FLAG     = 2'd0;
  localparam logic [1:0] MODE_MIN_AXIS = 2'd1;
  localparam logic [1:0] MODE_WEIGHTED = 2'd2;

  // Control bits that travel with every word down the pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
    logic weight;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// File: rtl/aop_front.sv
// Front stages: overlap test, raw penetration, magnitudes, products and squared targets.
`timescale 1ns / 1ps

module aop_front #(
  parameter int unsigned W = aop_pkg::COORD_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [1:0]          mode_i,
  input  logic signed [W-1:0] a_left_i,
  input  logic signed [W-1:0] a_top_i,
  input  logic signed [W-1:0] a_right_i,
  input  logic signed [W-1:0] a_bottom_i,
  input  logic signed [W-1:0] b_left_i,
  input  logic signed [W-1:0] b_top_i,
  input  logic signed [W-1:0] b_right_i,
  input  logic signed [W-1:0] b_bottom_i,
  input  logic signed [W-1:0] move_x_i,
  input  logic signed [W-1:0] move_y_i,
  output aop_pkg::ctl_t       ctl_o,
  output logic [W:0]          npx_o,
  output logic [W:0]          npy_o,
  output logic [4*W-1:0]      tx_o,
  output logic [4*W-1:0]      ty_o,
  output logic [2*W-1:0]      den_o
);
  import aop_pkg::*;

  localparam int unsigned DW = 2 * W;
  localparam int unsigned TW = 4 * W;

  // Stage A: registered input word.
  logic                valid_a_q;
  logic [1:0]          mode_q;
  logic signed [W-1:0] al_q, at_q, ar_q, ab_q, bl_q, bt_q, br_q, bb_q, mx_q, my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= mode_i;
      al_q   <= a_left_i;
      at_q   <= a_top_i;
      ar_q   <= a_right_i;
      ab_q   <= a_bottom_i;
      bl_q   <= b_left_i;
      bt_q   <= b_top_i;
      br_q   <= b_right_i;
      bb_q   <= b_bottom_i;
      mx_q   <= move_x_i;
      my_q   <= move_y_i;
    end
  end

  // Overlap test and per-axis penetration of B relative to A.
  logic              hit;
  logic signed [W:0] px, py, npx_d, npy_d;
  logic [W:0]        apx_w, apy_w, amx_w, amy_w;
  logic              keep_x, use_pen, weight;

  always_comb begin
    hit = !((al_q > br_q) || (ar_q < bl_q) || (at_q > bb_q) || (ab_q < bt_q));
    if ((bl_q >= al_q) && (bl_q <= ar_q)) begin
      px = {bl_q[W-1], bl_q} - {ar_q[W-1], ar_q};
    end else begin
      px = {br_q[W-1], br_q} - {al_q[W-1], al_q};
    end
    if ((bt_q >= at_q) && (bt_q <= ab_q)) begin
      py = {bt_q[W-1], bt_q} - {ab_q[W-1], ab_q};
    end else begin
      py = {bb_q[W-1], bb_q} - {at_q[W-1], at_q};
    end
    apx_w   = px[W] ? -px : px;
    apy_w   = py[W] ? -py : py;
    amx_w   = mx_q[W-1] ? -{mx_q[W-1], mx_q} : {mx_q[W-1], mx_q};
    amy_w   = my_q[W-1] ? -{my_q[W-1], my_q} : {my_q[W-1], my_q};
    keep_x  = !(apx_w > apy_w);
    use_pen = hit && ((mode_q == MODE_MIN_AXIS) || (mode_q == MODE_WEIGHTED));
    weight  = hit && (mode_q == MODE_WEIGHTED) && ((mx_q != '0) || (my_q != '0));
    npx_d   = (use_pen && keep_x) ? px : '0;
    npy_d   = (use_pen && !keep_x) ? py : '0;
  end

  // Stage B: magnitudes and control.
  ctl_t             ctl_b_q, ctl_c_q, ctl_d_q, ctl_e_q;
  logic [W:0]       npx_b_q, npy_b_q, npx_c_q, npy_c_q, npx_d_q, npy_d_q, npx_e_q, npy_e_q;
  logic [W-1:0]     apx_q, apy_q, amx_q, amy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_d_q <= '0;
      ctl_e_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= '{valid: valid_a_q, hit: hit, weight: weight, neg_x: px[W], neg_y: py[W]};
      ctl_c_q <= ctl_b_q;
      ctl_d_q <= ctl_c_q;
      ctl_e_q <= ctl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      npx_b_q <= npx_d;
      npy_b_q <= npy_d;
      apx_q   <= apx_w[W-1:0];
      apy_q   <= apy_w[W-1:0];
      amx_q   <= amx_w[W-1:0];
      amy_q   <= amy_w[W-1:0];
    end
  end

  // Stage C: movement squares and penetration-movement products.
  logic [DW-1:0] mx2_q, my2_q, prx_q, pry_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      npx_c_q <= npx_b_q;
      npy_c_q <= npy_b_q;
      mx2_q   <= DW'(amx_q) * DW'(amx_q);
      my2_q   <= DW'(amy_q) * DW'(amy_q);
      prx_q   <= DW'(apx_q) * DW'(amx_q);
      pry_q   <= DW'(apy_q) * DW'(amy_q);
    end
  end

  // Stage D: denominator and partial products of the squared products.
  logic [W-1:0]  xh, xl, yh, yl;
  logic [DW-1:0] den_q, xhh_q, xhl_q, xll_q, yhh_q, yhl_q, yll_q;

  assign xh = prx_q[DW-1:W];
  assign xl = prx_q[W-1:0];
  assign yh = pry_q[DW-1:W];
  assign yl = pry_q[W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      npx_d_q <= npx_c_q;
      npy_d_q <= npy_c_q;
      den_q   <= mx2_q + my2_q;
      xhh_q   <= DW'(xh) * DW'(xh);
      xhl_q   <= DW'(xh) * DW'(xl);
      xll_q   <= DW'(xl) * DW'(xl);
      yhh_q   <= DW'(yh) * DW'(yh);
      yhl_q   <= DW'(yh) * DW'(yl);
      yll_q   <= DW'(yl) * DW'(yl);
    end
  end

  // Stage E: sum of the partial products into the squared target.
  logic [TW-1:0] tx_q, ty_q;
  logic [DW-1:0] den_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      npx_e_q <= npx_d_q;
      npy_e_q <= npy_d_q;
      den_e_q <= den_q;
      tx_q    <= (TW'(xhh_q) << DW) + (TW'(xhl_q) << (W + 1)) + TW'(xll_q);
      ty_q    <= (TW'(yhh_q) << DW) + (TW'(yhl_q) << (W + 1)) + TW'(yll_q);
    end
  end

  assign ctl_o = ctl_e_q;
  assign npx_o = npx_e_q;
  assign npy_o = npy_e_q;
  assign tx_o  = tx_q;
  assign ty_o  = ty_q;
  assign den_o = den_e_q;

endmodule

// File: rtl/aop_cell.sv
// One cell of the weighting chain: decides one quotient bit by incremental squaring.
`timescale 1ns / 1ps

module aop_cell #(
  parameter int unsigned W = aop_pkg::COORD_BITS,
  parameter int unsigned K = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [4*W-1:0]   t_i,
  input  logic [2*W-1:0]   den_i,
  input  logic [4*W-1:0]   s_i,
  input  logic [3*W-1:0]   r_i,
  input  logic [W-1:0]     q_i,
  output logic [4*W-1:0]   t_o,
  output logic [2*W-1:0]   den_o,
  output logic [4*W-1:0]   s_o,
  output logic [3*W-1:0]   r_o,
  output logic [W-1:0]     q_o
);
  import aop_pkg::*;

  localparam int unsigned TW = 4 * W;
  localparam int unsigned RW = 3 * W;

  // With s = q*q*den and r = q*den, setting bit K gives
  // (q + 2^K)^2 * den = s + r * 2^(K+1) + den * 2^(2K).
  logic [TW-1:0] cand;
  logic          take;

  assign cand = s_i + (TW'(r_i) << (K + 1)) + (TW'(den_i) << (2 * K));
  assign take = (cand <= t_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o   <= t_i;
      den_o <= den_i;
      s_o   <= take ? cand : s_i;
      r_o   <= take ? (r_i + (RW'(den_i) << K)) : r_i;
      q_o   <= q_i | (W'(take) << K);
    end
  end

endmodule

// File: rtl/aabb_overlap_penetration_unit.sv
// Top level of the AABB overlap and penetration unit: front stages, bit cells, output register.
//
//  channel  | dir | tdata (low bit up)                                 | tuser
//  s_axis   | in  | a_left a_top a_right a_bottom b_left b_top b_right  | mode
//           |     | b_bottom move_x move_y                              |
//  m_axis   | out | collided pen_x pen_y                                | -
//
// One word is accepted per cycle while m_axis is not stalled; a word passes five front stages,
// one cell per quotient bit of the weighting chain, and the output register.
// Reset clears only the valid bits and the control words; no clearing pass is needed.
// A stall on m_axis freezes the whole pipeline, so s_axis_tready follows
// the output register being empty or taken.
`timescale 1ns / 1ps

module aabb_overlap_penetration_unit #(
  parameter int unsigned COORD_BITS = aop_pkg::COORD_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom, move_x, move_y
  input  logic [((10*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // mode
  input  logic [1:0]                               s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // collided, pen_x, pen_y
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0]      m_axis_tdata
);
  import aop_pkg::*;

  localparam int unsigned W   = COORD_BITS;
  localparam int unsigned TW  = 4 * W;
  localparam int unsigned DW  = 2 * W;
  localparam int unsigned RW  = 3 * W;
  localparam int unsigned ODW = ((2 * W + 3 + 7) / 8) * 8;

  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Front stages.
  ctl_t          ctl_f;
  logic [W:0]    npx_f, npy_f;
  logic [TW-1:0] tx_f, ty_f;
  logic [DW-1:0] den_f;

  aop_front #(.W(W)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .mode_i    (s_axis_tuser),
    .a_left_i  (s_axis_tdata[0*W +: W]),
    .a_top_i   (s_axis_tdata[1*W +: W]),
    .a_right_i (s_axis_tdata[2*W +: W]),
    .a_bottom_i(s_axis_tdata[3*W +: W]),
    .b_left_i  (s_axis_tdata[4*W +: W]),
    .b_top_i   (s_axis_tdata[5*W +: W]),
    .b_right_i (s_axis_tdata[6*W +: W]),
    .b_bottom_i(s_axis_tdata[7*W +: W]),
    .move_x_i  (s_axis_tdata[8*W +: W]),
    .move_y_i  (s_axis_tdata[9*W +: W]),
    .ctl_o     (ctl_f),
    .npx_o     (npx_f),
    .npy_o     (npy_f),
    .tx_o      (tx_f),
    .ty_o      (ty_f),
    .den_o     (den_f)
  );

  // Chain of bit cells, one per quotient bit from the top bit down, for both axes.
  logic [TW-1:0] tx_c [0:W];
  logic [TW-1:0] ty_c [0:W];
  logic [DW-1:0] dx_c [0:W];
  logic [DW-1:0] dy_c [0:W];
  logic [TW-1:0] sx_c [0:W];
  logic [TW-1:0] sy_c [0:W];
  logic [RW-1:0] rx_c [0:W];
  logic [RW-1:0] ry_c [0:W];
  logic [W-1:0]  qx_c [0:W];
  logic [W-1:0]  qy_c [0:W];
  ctl_t          ctl_c [0:W];
  logic [W:0]    npx_c [0:W];
  logic [W:0]    npy_c [0:W];

  assign tx_c[0]  = tx_f;
  assign ty_c[0]  = ty_f;
  assign dx_c[0]  = den_f;
  assign dy_c[0]  = den_f;
  assign sx_c[0]  = '0;
  assign sy_c[0]  = '0;
  assign rx_c[0]  = '0;
  assign ry_c[0]  = '0;
  assign qx_c[0]  = '0;
  assign qy_c[0]  = '0;
  assign ctl_c[0] = ctl_f;
  assign npx_c[0] = npx_f;
  assign npy_c[0] = npy_f;

  for (genvar i = 0; i < W; i++) begin : g_chain
    aop_cell #(.W(W), .K(W - 1 - i)) u_cell_x (
      .clk_i(clk_i), .en_i(en),
      .t_i(tx_c[i]), .den_i(dx_c[i]), .s_i(sx_c[i]), .r_i(rx_c[i]), .q_i(qx_c[i]),
      .t_o(tx_c[i+1]), .den_o(dx_c[i+1]), .s_o(sx_c[i+1]), .r_o(rx_c[i+1]),
      .q_o(qx_c[i+1])
    );
    aop_cell #(.W(W), .K(W - 1 - i)) u_cell_y (
      .clk_i(clk_i), .en_i(en),
      .t_i(ty_c[i]), .den_i(dy_c[i]), .s_i(sy_c[i]), .r_i(ry_c[i]), .q_i(qy_c[i]),
      .t_o(ty_c[i+1]), .den_o(dy_c[i+1]), .s_o(sy_c[i+1]), .r_o(ry_c[i+1]),
      .q_o(qy_c[i+1])
    );

    // Control and fallback penetration ride alongside the cells.
    ctl_t       ctl_q;
    logic [W:0] npx_q, npy_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (en) begin
        ctl_q <= ctl_c[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        npx_q <= npx_c[i];
        npy_q <= npy_c[i];
      end
    end

    assign ctl_c[i+1] = ctl_q;
    assign npx_c[i+1] = npx_q;
    assign npy_c[i+1] = npy_q;
  end

  // Final sign and selection into the output register.
  ctl_t       ctl_l;
  logic [W:0] qx_s, qy_s, pen_x_d, pen_y_d;
  logic       collided_q;
  logic [W:0] pen_x_q, pen_y_q;

  assign ctl_l = ctl_c[W];

  always_comb begin
    qx_s    = ctl_l.neg_x ? -{1'b0, qx_c[W]} : {1'b0, qx_c[W]};
    qy_s    = ctl_l.neg_y ? -{1'b0, qy_c[W]} : {1'b0, qy_c[W]};
    pen_x_d = ctl_l.weight ? qx_s : npx_c[W];
    pen_y_d = ctl_l.weight ? qy_s : npy_c[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_l.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      collided_q <= ctl_l.hit;
      pen_x_q    <= pen_x_d;
      pen_y_q    <= pen_y_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({pen_y_q, pen_x_q, collided_q});

endmodule

// File: rtl/aop_checker.sv
// Port-level checker for the AABB overlap unit and its bind to the top level.
`timescale 1ns / 1ps

module aop_checker #(
  parameter int unsigned COORD_BITS = aop_pkg::COORD_BITS
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  import aop_pkg::*;

  localparam int unsigned W = COORD_BITS;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No penetration is reported without an overlap.
  a_no_pen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2*W+2:1] == '0)
    else $error("penetration without overlap");

  // The input side is ready exactly when the output register can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output register");

endmodule

bind aabb_overlap_penetration_unit aop_checker #(.COORD_BITS(COORD_BITS)) u_aop_checker (.*);

// File: sim/tb_top.sv
// Testbench for the AABB overlap and penetration unit: directed table plus random words.
`timescale 1ns / 1ps

module tb_top;
  import aop_pkg::*;

  localparam int CB = 16;
  localparam int IW = ((10*CB+7)/8)*8;
  localparam int OW = ((2*CB+3+7)/8)*8;
  localparam int N_RAND = 1930;
  localparam int WATCH_LIMIT = 5000;
  localparam int LATENCY = CB + 6;

  // Mode code without a meaning; the unit treats it as flag only.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [1:0] mode;
    logic signed [CB-1:0] al, at, ar, ab, bl, bt, br, bb, mx, my;
  } rect_pair_t;

  typedef struct packed {
    logic hit;
    logic signed [CB:0] px;
    logic signed [CB:0] py;
  } pen_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [IW-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OW-1:0] m_axis_tdata;

  pen_t pen_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  aabb_overlap_penetration_unit #(.COORD_BITS(CB)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Largest q with q*q*den <= (|p|*|m|)^2, signed like p.
  function automatic longint scale_axis(longint p, longint m, longint den);
    longint ap, am, lo, hi, mid;
    logic [127:0] lhs, rhs;
    ap = p < 0 ? -p : p;
    am = m < 0 ? -m : m;
    lo = 0;
    hi = ap;
    rhs = 128'(ap * am) * 128'(ap * am);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 128'(mid * mid) * 128'(den);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return p < 0 ? -lo : lo;
  endfunction

  function automatic pen_t predict_pen(rect_pair_t r);
    pen_t o;
    longint px, py, den, apx, apy;
    o.hit = !(r.al > r.br || r.ar < r.bl || r.at > r.bb || r.ab < r.bt);
    px = 0;
    py = 0;
    if (o.hit && (r.mode == MODE_MIN_AXIS || r.mode == MODE_WEIGHTED)) begin
      if (r.bl >= r.al && r.bl <= r.ar) px = longint'(r.bl) - r.ar;
      else px = longint'(r.br) - r.al;
      if (r.bt >= r.at && r.bt <= r.ab) py = longint'(r.bt) - r.ab;
      else py = longint'(r.bb) - r.at;
      den = longint'(r.mx) * r.mx + longint'(r.my) * r.my;
      if (r.mode == MODE_WEIGHTED && den != 0) begin
        px = scale_axis(px, r.mx, den);
        py = scale_axis(py, r.my, den);
      end else begin
        apx = px < 0 ? -px : px;
        apy = py < 0 ? -py : py;
        if (apx > apy) px = 0;
        else py = 0;
      end
    end
    o.px = px[CB:0];
    o.py = py[CB:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic rect_pair_t mk(logic [1:0] md, int al, int at, int ar, int ab,
                                    int bl, int bt, int br, int bb, int mx, int my);
    rect_pair_t r;
    r.mode = md; r.al = CB'(al); r.at = CB'(at); r.ar = CB'(ar); r.ab = CB'(ab);
    r.bl = CB'(bl); r.bt = CB'(bt); r.br = CB'(br); r.bb = CB'(bb);
    r.mx = CB'(mx); r.my = CB'(my);
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'(16'h8000 + $urandom_range(0, 3));
      1: return 16'(16'h7fff - $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly overlapping pairs near a random center, with random movement.
  function automatic rect_pair_t rand_pair();
    rect_pair_t r;
    int c, s;
    r.mode = $urandom_range(0, 9) == 0 ? MODE_SPARE : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      r.al = rand_coord(); r.at = rand_coord(); r.ar = rand_coord(); r.ab = rand_coord();
      r.bl = rand_coord(); r.bt = rand_coord(); r.br = rand_coord(); r.bb = rand_coord();
    end else begin
      s = 1 << $urandom_range(1, 14);
      c = $signed(16'($urandom)) / 2;
      r.al = CB'(c + $urandom_range(0, s) - s / 2); r.ar = CB'(r.al + $urandom_range(0, s));
      r.bl = CB'(c + $urandom_range(0, s) - s / 2); r.br = CB'(r.bl + $urandom_range(0, s));
      c = $signed(16'($urandom)) / 2;
      r.at = CB'(c + $urandom_range(0, s) - s / 2); r.ab = CB'(r.at + $urandom_range(0, s));
      r.bt = CB'(c + $urandom_range(0, s) - s / 2); r.bb = CB'(r.bt + $urandom_range(0, s));
    end
    r.mx = $urandom_range(0, 7) == 0 ? 16'd0 : rand_coord();
    r.my = $urandom_range(0, 7) == 0 ? 16'd0 : rand_coord();
    return r;
  endfunction

  task automatic send_pair(rect_pair_t r, bit allow_gap);
    if (allow_gap && !quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= r.mode;
    s_axis_tdata <= IW'({r.my, r.mx, r.bb, r.br, r.bt, r.bl, r.ab, r.ar, r.at, r.al});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pen_queue.push_back(predict_pen(r));
    @(negedge clk_i);
  endtask

  // Receiver stalls in random bursts.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    pen_t e;
    logic signed [CB:0] gx, gy;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      gx = m_axis_tdata[CB+1:1];
      gy = m_axis_tdata[2*CB+2:CB+2];
      if (pen_queue.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = pen_queue.pop_front();
        if (m_axis_tdata[0] !== e.hit) report_mismatch("collided", m_axis_tdata[0], e.hit);
        if (gx !== e.px) report_mismatch("pen_x", gx, e.px);
        if (gy !== e.py) report_mismatch("pen_y", gy, e.py);
      end
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Directed table, then random traffic.
  initial begin
    rect_pair_t table_rows[$];
    pen_t known[$];
    bit has_known[$];
    pen_t k;
    int n;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_FLAG;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Rows with results easy to read off carry them; the rest use the predictor.
    table_rows.push_back(mk(MODE_FLAG, 0, 0, 10, 10, 5, 5, 15, 15, 0, 0));
    known.push_back('{1'b1, 17'sd0, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_MIN_AXIS, 0, 0, 10, 10, 20, 20, 30, 30, 1, 1));
    known.push_back('{1'b0, 17'sd0, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_MIN_AXIS, 0, 0, 10, 10, 10, 10, 20, 20, 0, 0));
    known.push_back('{1'b1, 17'sd0, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_MIN_AXIS, 0, 0, 10, 10, 8, 5, 20, 20, 0, 0));
    known.push_back('{1'b1, -17'sd2, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_MIN_AXIS, 0, 0, 10, 10, 7, 7, 20, 20, 0, 0));
    known.push_back('{1'b1, -17'sd3, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_WEIGHTED, 0, 0, 10, 10, 7, 5, 20, 20, 0, 0));
    known.push_back('{1'b1, -17'sd3, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_SPARE, 0, 0, 10, 10, 7, 5, 20, 20, 3, 4));
    known.push_back('{1'b1, 17'sd0, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_MIN_AXIS, -32768, -32768, 32767, 32767,
                            32767, 32767, -32768, -32768, 0, 0));
    known.push_back('{1'b1, 17'sd0, 17'sd0}); has_known.push_back(1);
    table_rows.push_back(mk(MODE_WEIGHTED, 0, 0, 10, 10, 7, 5, 20, 20, 3, 4));
    has_known.push_back(0); known.push_back(k);
    table_rows.push_back(mk(MODE_WEIGHTED, -32768, -32768, 32767, 32767,
                            32767, 32767, -32768, -32768, -32768, -32768));
    has_known.push_back(0); known.push_back(k);
    table_rows.push_back(mk(MODE_WEIGHTED, -32768, -32768, 32767, 32767,
                            -32768, -32768, 32767, 32767, 32767, 1));
    has_known.push_back(0); known.push_back(k);
    table_rows.push_back(mk(MODE_WEIGHTED, 10, 10, 0, 0, 5, 5, 5, 5, 0, -9));
    has_known.push_back(0); known.push_back(k);
    table_rows.push_back(mk(MODE_MIN_AXIS, 5, 5, 20, 20, 0, 0, 9, 30, 0, 0));
    has_known.push_back(0); known.push_back(k);

    foreach (table_rows[i]) begin
      send_pair(table_rows[i], 0);
      if (has_known[i]) begin
        k = predict_pen(table_rows[i]);
        if (k != known[i]) report_mismatch("table row", i, i);
        void'(pen_queue.pop_back());
        pen_queue.push_back(known[i]);
      end
    end
    s_axis_tvalid <= 0;

    // Sender holds off until the pipeline has drained.
    while (pen_queue.size() != 0) @(negedge clk_i);

    for (n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 200) quiet = 1;
      send_pair(rand_pair(), 1);
    end
    s_axis_tvalid <= 0;

    while (pen_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: filelist.f
rtl/aop_pkg.sv
rtl/aop_front.sv
rtl/aop_cell.sv
rtl/aabb_overlap_penetration_unit.sv
rtl/aop_checker.sv
sim/tb_top.sv
